// ===== rtl/core/dtcf_pkg.sv =====
// Shared types and constants for the dusk-triggered candle flicker unit.
// No dependencies.
package dtcf_pkg;

    localparam int DARK_W   = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [1:0] MODE_DAY   = 2'd0;
    localparam logic [1:0] MODE_NIGHT = 2'd1;
    localparam logic [1:0] MODE_BURN  = 2'd2;

    localparam logic [1:0] REG_NIGHT_LEVEL    = 2'd0;
    localparam logic [1:0] REG_DAY_LEVEL      = 2'd1;
    localparam logic [1:0] REG_TRIGGER_COUNT  = 2'd2;
    localparam logic [1:0] REG_CANDLE_MINUTES = 2'd3;

    localparam logic [7:0] NIGHT_LEVEL_RST    = 8'd30;
    localparam logic [7:0] DAY_LEVEL_RST      = 8'd4;
    localparam logic [7:0] TRIGGER_COUNT_RST  = 8'd5;
    localparam logic [7:0] CANDLE_MINUTES_RST = 8'd180;

    localparam logic [15:0] LCG_SEED = 16'h3333;
    localparam logic [11:0] LCG_MUL  = 12'd2053;
    localparam logic [15:0] LCG_INC  = 16'd13849;
    localparam logic [2:0]  STRENGTH_RST = 3'd4;
    localparam logic [7:0]  DUTY_MID = 8'd80;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef struct packed {
        logic capture;
        logic eval;
        logic step;
        logic update;
        logic load_out;
    } dtcf_cmd_t;

    typedef struct packed {
        logic need_update;
        logic out_full;
    } dtcf_status_t;

endpackage

// ===== rtl/core/dtcf_ctrl.sv =====
// Sequencer for one event: evaluate, optional LCG step and flicker update, result load.
// Depends on dtcf_pkg.
module dtcf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output dtcf_pkg::dtcf_cmd_t   cmd,
    input  dtcf_pkg::dtcf_status_t status
);
    import dtcf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_STEP,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.need_update ? ST_STEP : ST_DONE;
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/dtcf_datapath.sv =====
// Config registers, mode/confidence/flicker state, LCG and result register.
// Depends on dtcf_pkg.
module dtcf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dtcf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dtcf_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_op,
    input  logic [dtcf_pkg::DARK_W-1:0]         in_darkness,
    input  dtcf_pkg::dtcf_cmd_t                 cmd,
    output dtcf_pkg::dtcf_status_t              status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dtcf_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import dtcf_pkg::*;

    logic [7:0]  night_level_reg, day_level_reg, trigger_count_reg, candle_minutes_reg;
    logic        op_reg;
    logic [7:0]  dark_reg;
    logic [1:0]  mode_reg, mode_next;
    logic [7:0]  conf_reg, conf_next;
    logic [15:0] lcg_reg, lcg_next;
    logic [7:0]  upd_cnt_reg, upd_cnt_next;
    logic [7:0]  minutes_reg, minutes_next;
    logic [2:0]  strength_reg, strength_next;
    logic        pol_reg, pol_next;
    logic [7:0]  delay_reg, delay_next;
    logic [7:0]  duty_reg, duty_next;
    logic        out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic        waiting, up, hit;
    logic [7:0]  conf_step, delay_dec;
    logic [15:0] lcg_prod;
    logic        wrap;
    logic [2:0]  r, inv, str_new;
    logic [5:0]  swing6, r_sq;
    logic [7:0]  swing;
    logic [6:0]  delay7;
    logic [7:0]  min_dec;
    logic        burning;

    assign waiting   = (mode_reg == MODE_DAY) || (mode_reg == MODE_NIGHT);
    assign up        = (mode_reg == MODE_NIGHT) ? (dark_reg > night_level_reg)
                                                : (dark_reg <= day_level_reg);
    assign conf_step = up ? ((conf_reg == 8'hFF) ? conf_reg : conf_reg + 8'd1)
                          : ((conf_reg != 8'd0) ? conf_reg - 8'd1 : conf_reg);
    assign hit       = (conf_step >= trigger_count_reg);
    assign delay_dec = (delay_reg != 8'd0) ? delay_reg - 8'd1 : delay_reg;

    assign lcg_prod  = lcg_reg * {4'd0, LCG_MUL};

    assign wrap    = (upd_cnt_reg == 8'd0);
    assign r       = lcg_reg[15:13];
    assign inv     = 3'd7 - r;
    assign str_new = wrap ? (3'd1 + {1'b0, lcg_reg[15:14]}) : strength_reg;
    assign swing6  = {3'd0, str_new} * {3'd0, inv};
    assign swing   = {1'b0, swing6, 1'b0};
    assign r_sq    = {3'd0, r} * {3'd0, r};
    assign delay7  = {1'b0, r_sq} + {3'd0, r, 1'b0} + 7'd4;
    assign min_dec = wrap ? minutes_reg - 8'd1 : minutes_reg;

    always_comb
    begin
        mode_next     = mode_reg;
        conf_next     = conf_reg;
        lcg_next      = lcg_reg;
        upd_cnt_next  = upd_cnt_reg;
        minutes_next  = minutes_reg;
        strength_next = strength_reg;
        pol_next      = pol_reg;
        delay_next    = delay_reg;
        duty_next     = duty_reg;
        status.need_update = 1'b0;
        status.out_full    = out_valid_reg && !m_tready;

        if (cmd.eval)
        begin
            if (op_reg == OP_MEASURE && waiting)
            begin
                conf_next = conf_step;
                if (hit)
                begin
                    conf_next = 8'd0;
                    if (mode_reg == MODE_DAY)
                    begin
                        mode_next = MODE_NIGHT;
                    end
                    else
                    begin
                        upd_cnt_next = 8'd0;
                        delay_next   = 8'd0;
                        minutes_next = candle_minutes_reg;
                        if (candle_minutes_reg == 8'd0)
                        begin
                            mode_next = MODE_DAY;
                        end
                        else
                        begin
                            mode_next = MODE_BURN;
                            status.need_update = 1'b1;
                        end
                    end
                end
            end
            else if (op_reg == OP_TICK && mode_reg == MODE_BURN)
            begin
                delay_next = delay_dec;
                status.need_update = (delay_dec == 8'd0);
            end
        end

        if (cmd.step)
        begin
            lcg_next     = lcg_prod + LCG_INC;
            upd_cnt_next = upd_cnt_reg + 8'd1;
        end

        if (cmd.update)
        begin
            minutes_next  = min_dec;
            strength_next = str_new;
            pol_next      = !pol_reg;
            duty_next     = !pol_reg ? DUTY_MID - swing : DUTY_MID + swing;
            delay_next    = {delay7, 1'b0};
            if (min_dec == 8'd0)
            begin
                mode_next = MODE_DAY;
                conf_next = 8'd0;
            end
        end
    end

    assign burning = (mode_reg == MODE_BURN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            night_level_reg    <= NIGHT_LEVEL_RST;
            day_level_reg      <= DAY_LEVEL_RST;
            trigger_count_reg  <= TRIGGER_COUNT_RST;
            candle_minutes_reg <= CANDLE_MINUTES_RST;
            mode_reg      <= MODE_NIGHT;
            conf_reg      <= 8'd0;
            lcg_reg       <= LCG_SEED;
            upd_cnt_reg   <= 8'd0;
            minutes_reg   <= 8'd0;
            strength_reg  <= STRENGTH_RST;
            pol_reg       <= 1'b0;
            delay_reg     <= 8'd0;
            duty_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_NIGHT_LEVEL:    night_level_reg    <= cfg_data;
                    REG_DAY_LEVEL:      day_level_reg      <= cfg_data;
                    REG_TRIGGER_COUNT:  trigger_count_reg  <= cfg_data;
                    REG_CANDLE_MINUTES: candle_minutes_reg <= cfg_data;
                    default:            night_level_reg    <= night_level_reg;
                endcase
            end
            mode_reg     <= mode_next;
            conf_reg     <= conf_next;
            lcg_reg      <= lcg_next;
            upd_cnt_reg  <= upd_cnt_next;
            minutes_reg  <= minutes_next;
            strength_reg <= strength_next;
            pol_reg      <= pol_next;
            delay_reg    <= delay_next;
            duty_reg     <= duty_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_op;
            dark_reg <= in_darkness;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {5'd0,
                             burning ? minutes_reg : 8'd0,
                             mode_reg,
                             burning ? duty_reg : 8'd0,
                             burning};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/core/dusk_triggered_candle_flicker_unit.sv =====
// Top level of the dusk-triggered candle flicker unit.
// Depends on dtcf_pkg, dtcf_ctrl and dtcf_datapath.
//
// Input stream: one beat per event. s_tuser is the op (0 light measurement,
// 1 flicker tick), s_tdata carries the darkness reading. Output stream: one
// result beat per event with pwm_enable, duty, mode_now and minutes_left.
// Config: cfg_we/cfg_index/cfg_data write night_level (0), day_level (1),
// trigger_count (2) and candle_minutes (3); write only while idle.
//
// An event that causes no flicker update runs through the evaluate and done
// states of the controller; one that steps the LCG and updates the duty runs
// through evaluate, LCG step, update and done. m_tvalid rises once the result
// is loaded into the output register. One event is in work at a time; a new
// beat is accepted once the previous result sits in the output register,
// even if it has not been taken.
// When m_tready stays low, the finished result of the following event waits
// in the controller until the output register frees, and s_tready stays low.
// Reset: waiting for night, confidence 0, LCG seed 0x3333, registers at their
// defaults, no result pending.
module dusk_triggered_candle_flicker_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [dtcf_pkg::IN_TDATA_W-1:0]      s_tdata,   // [7:0] darkness
    input  logic                                 s_tuser,   // [0] op
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] pwm_enable, [8:1] duty, [10:9] mode_now, [18:11] minutes_left
    output logic [dtcf_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_we,
    input  logic [dtcf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dtcf_pkg::CFG_W-1:0]           cfg_data
);
    import dtcf_pkg::*;

    dtcf_cmd_t    cmd;
    dtcf_status_t status;

    dtcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    dtcf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_op       (s_tuser),
        .in_darkness (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second event accepted while one is in work");

    a_burn_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[10:9] == MODE_BURN)))
        else $error("pwm_enable disagrees with mode");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[8:1] >= 8'd24 && m_tdata[8:1] <= 8'd136))
        else $error("burning duty out of range");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[8:1] == 8'd0 && m_tdata[18:11] == 8'd0))
        else $error("duty or minutes nonzero while not burning");

endmodule

// ===== verif/dtcf_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the dusk-triggered candle flicker unit: tracks register writes,
// predicts one result per accepted event and compares it with the output beats.
// Depends on dtcf_pkg.
module dtcf_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [dtcf_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] darkness
    input  logic                               s_tuser,   // [0] op
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] pwm_enable, [8:1] duty, [10:9] mode_now, [18:11] minutes_left
    input  logic [dtcf_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_we,
    input  logic [dtcf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dtcf_pkg::CFG_W-1:0]         cfg_data,
    output int                                 fail_count,
    output int                                 pending,
    output logic [1:0]                         model_mode
);
    import dtcf_pkg::*;

    typedef struct packed {
        logic       pwm_enable;
        logic [7:0] duty;
        logic [1:0] mode_now;
        logic [7:0] minutes_left;
    } glow_t;

    glow_t glow_q[$];

    logic [7:0]  night_lvl, day_lvl, trig_cnt, burn_minutes;
    logic [1:0]  phase;
    logic [7:0]  confidence, update_cnt, minutes_rem, tick_wait, duty_now;
    logic [15:0] lcg_state;
    logic [2:0]  strength;
    logic        negative;

    task automatic flicker_step();
        int r;
        int swing;
        lcg_state = lcg_state * LCG_MUL + LCG_INC;
        update_cnt = update_cnt + 8'd1;
        if (update_cnt == 8'd0)
        begin
            minutes_rem = minutes_rem - 8'd1;
            strength = 3'd1 + {1'b0, lcg_state[15:14]};
        end
        r = int'(lcg_state[15:13]);
        negative = !negative;
        swing = 2 * int'(strength) * (7 - r);
        duty_now = negative ? 8'(80 - swing) : 8'(80 + swing);
        tick_wait = 8'(2 * (r * r + 2 * r + 4));
        if (minutes_rem == 8'd0)
        begin
            phase = MODE_DAY;
            confidence = 8'd0;
        end
    endtask

    task automatic light_candle();
        confidence = 8'd0;
        update_cnt = 8'd0;
        tick_wait = 8'd0;
        minutes_rem = burn_minutes;
        if (minutes_rem == 8'd0)
        begin
            phase = MODE_DAY;
        end
        else
        begin
            phase = MODE_BURN;
            flicker_step();
        end
    endtask

    task automatic predict_glow(input logic op, input logic [7:0] dark, output glow_t res);
        logic up;
        if (op == OP_MEASURE && (phase == MODE_DAY || phase == MODE_NIGHT))
        begin
            up = (phase == MODE_NIGHT) ? (dark > night_lvl) : (dark <= day_lvl);
            if (up)
            begin
                if (confidence != 8'hFF)
                    confidence = confidence + 8'd1;
            end
            else if (confidence != 8'd0)
            begin
                confidence = confidence - 8'd1;
            end
            if (confidence >= trig_cnt)
            begin
                confidence = 8'd0;
                if (phase == MODE_DAY)
                    phase = MODE_NIGHT;
                else
                    light_candle();
            end
        end
        else if (op == OP_TICK && phase == MODE_BURN)
        begin
            if (tick_wait != 8'd0)
                tick_wait = tick_wait - 8'd1;
            if (tick_wait == 8'd0)
                flicker_step();
        end
        res.pwm_enable   = (phase == MODE_BURN);
        res.duty         = (phase == MODE_BURN) ? duty_now : 8'd0;
        res.mode_now     = phase;
        res.minutes_left = (phase == MODE_BURN) ? minutes_rem : 8'd0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        glow_t want;
        glow_t seen;
        if (!rst_n)
        begin
            glow_q.delete();
            fail_count = 0;
            night_lvl = NIGHT_LEVEL_RST;
            day_lvl = DAY_LEVEL_RST;
            trig_cnt = TRIGGER_COUNT_RST;
            burn_minutes = CANDLE_MINUTES_RST;
            phase = MODE_NIGHT;
            confidence = 8'd0;
            lcg_state = LCG_SEED;
            update_cnt = 8'd0;
            minutes_rem = 8'd0;
            strength = STRENGTH_RST;
            negative = 1'b0;
            tick_wait = 8'd0;
            duty_now = 8'd0;
            pending <= 0;
            model_mode <= MODE_NIGHT;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.pwm_enable   = m_tdata[0];
                seen.duty         = m_tdata[8:1];
                seen.mode_now     = m_tdata[10:9];
                seen.minutes_left = m_tdata[18:11];
                if (glow_q.size() == 0)
                begin
                    $error("result beat with no event outstanding: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = glow_q.pop_front();
                    if (seen.pwm_enable !== want.pwm_enable)
                    begin
                        $error("pwm_enable: expected %0d, got %0d",
                               want.pwm_enable, seen.pwm_enable);
                        fail_count++;
                    end
                    if (seen.duty !== want.duty)
                    begin
                        $error("duty: expected %0d, got %0d", want.duty, seen.duty);
                        fail_count++;
                    end
                    if (seen.mode_now !== want.mode_now)
                    begin
                        $error("mode_now: expected %0d, got %0d",
                               want.mode_now, seen.mode_now);
                        fail_count++;
                    end
                    if (seen.minutes_left !== want.minutes_left)
                    begin
                        $error("minutes_left: expected %0d, got %0d",
                               want.minutes_left, seen.minutes_left);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NIGHT_LEVEL:    night_lvl = cfg_data;
                    REG_DAY_LEVEL:      day_lvl = cfg_data;
                    REG_TRIGGER_COUNT:  trig_cnt = cfg_data;
                    REG_CANDLE_MINUTES: burn_minutes = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                predict_glow(s_tuser, s_tdata[7:0], want);
                glow_q.push_back(want);
            end
            pending <= glow_q.size();
            model_mode <= phase;
        end
    end

endmodule

// ===== verif/dusk_triggered_candle_flicker_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the dusk-triggered candle flicker unit: directed and random
// event streams with random back-pressure; checking is done in dtcf_checker.
// Depends on dtcf_pkg, dusk_triggered_candle_flicker_unit and dtcf_checker.
module dusk_triggered_candle_flicker_unit_tb;
    import dtcf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 10_000_000;
    localparam int RANDOM_EVENTS = 800;
    localparam int CALM_TAIL = 150;
    localparam int BURN_TICKS = 200;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    int          fail_count;
    int          pending;
    logic [1:0]  model_mode;
    logic        idle_on = 1'b1;
    int          stall_left = 0;
    int unsigned cycle_cnt = 0;
    logic [7:0]  night_cfg = NIGHT_LEVEL_RST;
    logic [7:0]  day_cfg = DAY_LEVEL_RST;

    always #5 clk = ~clk;

    dusk_triggered_candle_flicker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dtcf_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .model_mode (model_mode)
    );

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 14);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_beat(input logic op, input logic [7:0] dark);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= dark;
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] night, input logic [7:0] day,
                             input logic [7:0] trig, input logic [7:0] minutes);
        wait_quiet();
        write_reg(REG_NIGHT_LEVEL, night);
        write_reg(REG_DAY_LEVEL, day);
        write_reg(REG_TRIGGER_COUNT, trig);
        write_reg(REG_CANDLE_MINUTES, minutes);
        cfg_we <= 1'b0;
        night_cfg = night;
        day_cfg = day;
    endtask

    // mostly qualifying readings while waiting, mostly ticks while burning
    task automatic random_event(output bit counts);
        logic       op;
        logic [7:0] dark;
        op = OP_MEASURE;
        dark = 8'($urandom_range(0, 255));
        counts = 1'b0;
        case (model_mode)
            MODE_BURN:
            begin
                if ($urandom_range(0, 15) != 0)
                    op = OP_TICK;
            end
            MODE_NIGHT:
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    op = OP_TICK;
                end
                else
                begin
                    counts = 1'b1;
                    if ($urandom_range(0, 3) != 0 && night_cfg != 8'hFF)
                        dark = 8'($urandom_range(night_cfg + 1, 255));
                end
            end
            default:
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    op = OP_TICK;
                end
                else
                begin
                    counts = 1'b1;
                    if ($urandom_range(0, 3) != 0)
                        dark = 8'($urandom_range(0, day_cfg));
                end
            end
        endcase
        send_beat(op, dark);
    endtask

    initial
    begin
        int  done;
        int  quota;
        int  cnt;
        int  trig;
        bit  counts;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: tick while waiting, readings around the night threshold
        send_beat(OP_TICK, 8'hFF);
        send_beat(OP_MEASURE, 8'd31);
        send_beat(OP_MEASURE, 8'd30);
        send_beat(OP_MEASURE, 8'd0);
        send_beat(OP_MEASURE, 8'd255);
        send_beat(OP_MEASURE, 8'd255);
        send_beat(OP_MEASURE, 8'd255);
        send_beat(OP_MEASURE, 8'd4);
        send_beat(OP_TICK, 8'd0);

        // zero trigger count and zero burn length
        configure(8'd0, 8'd255, 8'd0, 8'd0);
        send_beat(OP_MEASURE, 8'd0);
        send_beat(OP_MEASURE, 8'd200);
        send_beat(OP_MEASURE, 8'd1);
        send_beat(OP_TICK, 8'hAA);

        // top extremes
        configure(8'd255, 8'd0, 8'd255, 8'd255);
        send_beat(OP_MEASURE, 8'd0);
        send_beat(OP_MEASURE, 8'd1);
        send_beat(OP_MEASURE, 8'd255);
        send_beat(OP_MEASURE, 8'd0);

        // zero burn length keeps the random phase cycling day -> night -> day
        done = 0;
        while (done < RANDOM_EVENTS)
        begin
            trig = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 255) : $urandom_range(1, 8);
            configure(8'($urandom_range(0, 254)), 8'($urandom_range(0, 255)), 8'(trig),
                      8'd0);
            idle_on <= (done < RANDOM_EVENTS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            quota = $urandom_range(40, 120);
            cnt = 0;
            while (cnt < quota)
            begin
                random_event(counts);
                if (counts)
                    cnt++;
            end
            done += cnt;
        end

        // day -> night -> burn, then events during the burn
        configure(8'd100, 8'd50, 8'd1, 8'd1);
        send_beat(OP_MEASURE, 8'd50);
        send_beat(OP_MEASURE, 8'd100);
        send_beat(OP_MEASURE, 8'd101);
        send_beat(OP_MEASURE, 8'd255);
        repeat (BURN_TICKS) send_beat(OP_TICK, 8'($urandom_range(0, 255)));

        wait_quiet();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
